### design/assert_macros.svh
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Assert that an antecedent implies a consequent in the same cycle
`define CHK_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Assert that an antecedent implies a consequent in the next cycle
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

### design/md4_pkg.sv
// Package with MD4 types, constants and step tables
package md4_pkg;
    localparam logic [31:0] INIT_A = 32'h67452301;
    localparam logic [31:0] INIT_B = 32'hefcdab89;
    localparam logic [31:0] INIT_C = 32'h98badcfe;
    localparam logic [31:0] INIT_D = 32'h10325476;
    localparam logic [31:0] K2 = 32'h5a827999;
    localparam logic [31:0] K3 = 32'h6ed9eba1;
    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam int QDEPTH = 4;

    typedef struct packed {
        logic [7:0] data;
        logic       present;
        logic       final_flag;
        logic       expand;
    } md4_req_t;

    // Word index for step s (0..47)
    function automatic logic [3:0] word_sel(input logic [5:0] s);
        logic [3:0] i;
        i = s[3:0];
        case (s[5:4])
            2'd0: word_sel = i;
            2'd1: word_sel = {i[1:0], i[3:2]};
            default: word_sel = {i[0], i[1], i[2], i[3]};
        endcase
    endfunction

    function automatic logic [4:0] rot_sel(input logic [5:0] s);
        case ({s[5:4], s[1:0]})
            4'b0000: rot_sel = 5'd3;
            4'b0001: rot_sel = 5'd7;
            4'b0010: rot_sel = 5'd11;
            4'b0011: rot_sel = 5'd19;
            4'b0100: rot_sel = 5'd3;
            4'b0101: rot_sel = 5'd5;
            4'b0110: rot_sel = 5'd9;
            4'b0111: rot_sel = 5'd13;
            4'b1000: rot_sel = 5'd3;
            4'b1001: rot_sel = 5'd9;
            4'b1010: rot_sel = 5'd11;
            default: rot_sel = 5'd15;
        endcase
    endfunction
endpackage

### design/md4_if.sv
// Valid/ready channel interfaces
interface md4_in_if (input logic clk);
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       byte_present;
    logic       final_item;
    modport source (output valid, data_byte, byte_present, final_item, input ready);
    modport sink (input valid, data_byte, byte_present, final_item, output ready);
endinterface

interface md4_out_if (input logic clk);
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [1:0]  word_index;
    logic        last_word;
    modport source (output valid, digest_word, word_index, last_word, input ready);
    modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface

interface md4_cfg_if (input logic clk);
    logic valid;
    logic ready;
    logic utf16_expand;
    modport source (output valid, utf16_expand, input ready);
    modport sink (input valid, utf16_expand, output ready);
endinterface

### design/md4_front.sv
// Front end: accept requests, tag with mode, queue for the core
module md4_front (
    input  logic                clk,
    input  logic                rst_n,
    md4_in_if.sink              in_ch,
    md4_cfg_if.sink             cfg,
    output md4_pkg::md4_req_t   q_data,
    output logic                q_valid,
    input  logic                q_pop
);
    localparam int AW = $clog2(md4_pkg::QDEPTH);

    md4_pkg::md4_req_t mem [md4_pkg::QDEPTH];
    logic [AW-1:0] wr_reg, rd_reg;
    logic [AW:0]   cnt_reg;
    logic          expand_reg;
    logic          push;

    assign cfg.ready = 1'b1;
    assign in_ch.ready = (cnt_reg != (AW+1)'(md4_pkg::QDEPTH));
    assign push = in_ch.valid && in_ch.ready;
    assign q_valid = (cnt_reg != '0);
    assign q_data = mem[rd_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_reg] <= '{data: in_ch.data_byte, present: in_ch.byte_present,
                            final_flag: in_ch.final_item, expand: expand_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg <= '0;
            rd_reg <= '0;
            cnt_reg <= '0;
            expand_reg <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
                expand_reg <= cfg.utf16_expand;
            if (push)
                wr_reg <= wr_reg + 1'b1;
            if (q_pop)
                rd_reg <= rd_reg + 1'b1;
            cnt_reg <= cnt_reg + (AW+1)'(push) - (AW+1)'(q_pop);
        end
    end
endmodule

### design/md4_core.sv
// Back end: byte packing, padding, 48-step compression and digest output
module md4_core (
    input  logic               clk,
    input  logic               rst_n,
    input  md4_pkg::md4_req_t  q_data,
    input  logic               q_valid,
    output logic               q_pop,
    md4_out_if.source          out_ch
);
    typedef enum logic [2:0] {IDLE, ZEXP, PADB, COMP, EMIT} state_t;

    state_t        state_reg;
    logic [31:0]   chain_reg [4];
    logic [31:0]   v_reg [4];
    logic [31:0]   buf_reg [16];
    logic [5:0]    pos_reg;
    logic [63:0]   cnt_reg;
    logic [63:0]   len_reg;
    logic [5:0]    step_reg;
    logic          fin_reg;
    logic          padz_reg;   // 0x80 already placed
    logic          lenph_reg;  // padding reached byte 55, length bytes follow
    logic [1:0]    oidx_reg;
    state_t        ret_reg;

    logic [7:0]  put_byte;
    logic        put_en;
    logic        put_cnt;
    logic [5:0]  pos_next;
    logic [7:0]  pad_byte;
    logic [1:0]  t;
    logic [31:0] x, y, z, f, sum, rot;
    logic [4:0]  sh;

    // padding byte for current position
    always_comb
    begin
        if (!padz_reg)
            pad_byte = md4_pkg::PAD_BYTE;
        else if (lenph_reg)
            pad_byte = len_reg[8*pos_reg[2:0] +: 8];
        else
            pad_byte = 8'h00;
    end

    always_comb
    begin
        put_en = 1'b0;
        put_cnt = 1'b0;
        put_byte = 8'h00;
        q_pop = 1'b0;
        case (state_reg)
            IDLE:
            begin
                if (q_valid && !out_ch.valid)
                begin
                    q_pop = 1'b1;
                    put_en = q_data.present;
                    put_cnt = q_data.present;
                    put_byte = q_data.data;
                end
            end
            ZEXP:
            begin
                put_en = 1'b1;
                put_cnt = 1'b1;
            end
            PADB:
            begin
                put_en = 1'b1;
                put_byte = pad_byte;
            end
            default: ;
        endcase
        pos_next = pos_reg + 6'd1;
    end

    // compression step datapath
    always_comb
    begin
        t = 2'(3'd4 - {1'b0, step_reg[1:0]});
        x = v_reg[t + 2'd1];
        y = v_reg[t + 2'd2];
        z = v_reg[t + 2'd3];
        case (step_reg[5:4])
            2'd0: f = (x & y) | (~x & z);
            2'd1: f = ((x & y) | (x & z) | (y & z)) + md4_pkg::K2;
            default: f = (x ^ y ^ z) + md4_pkg::K3;
        endcase
        sum = v_reg[t] + f + buf_reg[md4_pkg::word_sel(step_reg)];
        sh = md4_pkg::rot_sel(step_reg);
        rot = (sum << sh) | (sum >> (6'd32 - {1'b0, sh}));
    end

    assign out_ch.digest_word = chain_reg[oidx_reg];
    assign out_ch.word_index = oidx_reg;
    assign out_ch.last_word = (oidx_reg == 2'd3);
    assign out_ch.valid = (state_reg == EMIT);

    always_ff @(posedge clk)
    begin
        if (put_en)
            buf_reg[pos_reg[5:2]][8*pos_reg[1:0] +: 8] <= put_byte;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= IDLE;
            chain_reg <= '{md4_pkg::INIT_A, md4_pkg::INIT_B, md4_pkg::INIT_C,
                           md4_pkg::INIT_D};
            v_reg <= '{default: '0};
            pos_reg <= '0;
            cnt_reg <= '0;
            len_reg <= '0;
            step_reg <= '0;
            fin_reg <= 1'b0;
            padz_reg <= 1'b0;
            lenph_reg <= 1'b0;
            oidx_reg <= '0;
            ret_reg <= IDLE;
        end
        else
        begin
            if (put_en)
                pos_reg <= pos_next;
            if (put_cnt)
                cnt_reg <= cnt_reg + 64'd8;
            case (state_reg)
                IDLE:
                begin
                    if (q_pop)
                    begin
                        fin_reg <= q_data.final_flag;
                        // decide what follows this byte; a full block compresses first
                        if (q_data.present && pos_next == 6'd0)
                        begin
                            state_reg <= COMP;
                            if (q_data.expand)
                                ret_reg <= ZEXP;
                            else
                                ret_reg <= q_data.final_flag ? PADB : IDLE;
                        end
                        else if (q_data.present && q_data.expand)
                            state_reg <= ZEXP;
                        else if (q_data.final_flag)
                            state_reg <= PADB;
                        if (q_data.final_flag && !(q_data.present && q_data.expand))
                            len_reg <= cnt_reg + (q_data.present ? 64'd8 : 64'd0);
                        step_reg <= '0;
                        v_reg <= chain_reg;
                    end
                end
                ZEXP:
                begin
                    if (fin_reg)
                        len_reg <= cnt_reg + 64'd8;
                    step_reg <= '0;
                    v_reg <= chain_reg;
                    if (pos_next == 6'd0)
                    begin
                        state_reg <= COMP;
                        ret_reg <= fin_reg ? PADB : IDLE;
                    end
                    else
                        state_reg <= fin_reg ? PADB : IDLE;
                end
                PADB:
                begin
                    padz_reg <= 1'b1;
                    if (pos_reg == 6'd55)
                        lenph_reg <= 1'b1;
                    step_reg <= '0;
                    v_reg <= chain_reg;
                    if (pos_reg == 6'd63)
                    begin
                        state_reg <= COMP;
                        ret_reg <= lenph_reg ? EMIT : PADB;
                    end
                end
                COMP:
                begin
                    v_reg[t] <= rot;
                    step_reg <= step_reg + 6'd1;
                    if (step_reg == 6'd47)
                    begin
                        // fold the last step's result straight into its chain word
                        for (int k = 0; k < 4; k++)
                            chain_reg[k] <= chain_reg[k] + ((2'(k) == t) ? rot : v_reg[k]);
                        state_reg <= ret_reg;
                        oidx_reg <= '0;
                    end
                end
                EMIT:
                begin
                    if (out_ch.ready)
                    begin
                        oidx_reg <= oidx_reg + 2'd1;
                        if (oidx_reg == 2'd3)
                        begin
                            state_reg <= IDLE;
                            chain_reg <= '{md4_pkg::INIT_A, md4_pkg::INIT_B,
                                           md4_pkg::INIT_C, md4_pkg::INIT_D};
                            cnt_reg <= '0;
                            padz_reg <= 1'b0;
                            lenph_reg <= 1'b0;
                        end
                    end
                end
                default: state_reg <= IDLE;
            endcase
        end
    end
endmodule

### design/md4_digest_engine_unit.sv
// Top level of the byte-serial MD4 digest engine
// Each byte is written by the back end from IDLE (plus a ZEXP zero byte with
// UTF-16 expansion); a full 64-byte block then runs the single-step compression
// loop. A final request adds padding (0x80, zeros, 64-bit length; one or two
// blocks), then four digest words. Throughput is bounded by the compression unit.
// Reset (rst_n, async low) restores the MD4 initial values and empties the queue.
module md4_digest_engine_unit (
    input  logic       clk,
    input  logic       rst_n,
    md4_in_if.sink     in_ch,
    md4_cfg_if.sink    cfg,
    md4_out_if.source  out_ch
);
    md4_pkg::md4_req_t q_data;
    logic              q_valid;
    logic              q_pop;

    md4_front u_front (
        .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .cfg(cfg),
        .q_data(q_data), .q_valid(q_valid), .q_pop(q_pop)
    );

    md4_core u_core (
        .clk(clk), .rst_n(rst_n), .q_data(q_data), .q_valid(q_valid),
        .q_pop(q_pop), .out_ch(out_ch)
    );
endmodule

### design/md4_checker.sv
// Port-level checker for the digest engine, bound to the top level
`include "assert_macros.svh"
module md4_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [1:0]  word_index,
    input logic        last_word
);
    `CHK_SAME(a_last, clk, rst_n, out_valid, last_word == (word_index == 2'd3), "last_word mismatch")
    `CHK_NEXT(a_adv, clk, rst_n, out_valid && out_ready && !last_word, out_valid && word_index == $past(word_index) + 2'd1, "digest words not consecutive")
    `CHK_NEXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(word_index), "output dropped under stall")
endmodule

bind md4_digest_engine_unit md4_checker u_md4_checker (
    .clk(clk), .rst_n(rst_n), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .word_index(out_ch.word_index), .last_word(out_ch.last_word)
);
